@@ design/chained_xor_packet_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// Chained XOR packet cipher assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_XOR_PACKET_CIPHER_ASSERT_SVH
`define CHAINED_XOR_PACKET_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define CXPC_AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cipher check failed");

// Next-cycle implication, disabled in reset
`define CXPC_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cipher check failed");

`endif

@@ design/cxpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained XOR packet cipher package
// Command and register codes, key reset values and control types.
// ----------------------------------------------------------------------------
package cxpc_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ENC  = 2'd0;
  localparam cmd_t CMD_DEC  = 2'd1;
  localparam cmd_t CMD_NEWS = 2'd2;
  localparam cmd_t CMD_NONE = 2'd3;

  localparam logic [1:0] REG_KEY_LO = 2'd0;
  localparam logic [1:0] REG_KEY_HI = 2'd1;
  localparam logic [1:0] REG_DEC_EN = 2'd2;
  localparam logic [1:0] REG_NONE   = 2'd3;

  localparam logic [31:0] KEY_LOW_RESET  = 32'h0000_3594;
  localparam logic [31:0] KEY_HIGH_RESET = 32'h8754_6CA1;

  typedef struct packed {
    logic step;
    logic last;
    logic reload;
  } dir_ctl_t;

endpackage

@@ design/cxpc_dir.sv @@
// ----------------------------------------------------------------------------
// Cipher direction engine
// Rolling key, chain byte and position count for one direction.
// ----------------------------------------------------------------------------
module cxpc_dir
  import cxpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dir_ctl_t    ctl,
  input  logic [63:0] init_key,
  input  logic        chain_on_out,
  input  logic [7:0]  data_in,
  output logic [7:0]  data_out
);

  logic [63:0] key_r, key_nxt;
  logic [7:0]  chain_r, chain_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] count_inc;
  logic [7:0]  key_byte;

  assign key_byte  = key_r[{count_r[2:0], 3'b000} +: 8];
  assign data_out  = data_in ^ key_byte ^ chain_r;
  assign count_inc = count_r + 16'd1;

  always_comb begin
    key_nxt   = key_r;
    chain_nxt = chain_r;
    count_nxt = count_r;
    if (ctl.reload) begin
      key_nxt   = init_key;
      chain_nxt = 8'd0;
      count_nxt = 16'd0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        key_nxt   = {key_r[63:32], key_r[31:0] + {16'd0, count_inc}};
        chain_nxt = 8'd0;
        count_nxt = 16'd0;
      end else begin
        chain_nxt = chain_on_out ? data_out : data_in;
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= {KEY_HIGH_RESET, KEY_LOW_RESET};
      chain_r <= 8'd0;
      count_r <= 16'd0;
    end else begin
      key_r   <= key_nxt;
      chain_r <= chain_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ design/chained_xor_packet_cipher.sv @@
// ----------------------------------------------------------------------------
// Chained XOR packet cipher
// Pipeline: an accepted request is registered in stage 1, its result in
// the output register behind out_valid. Throughput: one request per
// cycle unless a held result stalls it, set by each engine's chain and count update.
// Reset: synchronous, active low; keys load the register reset values,
// chains and counts clear, both pipeline stages empty.
// ----------------------------------------------------------------------------
module chained_xor_packet_cipher
  import cxpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] key_lo_r, key_hi_r;
  logic        dec_en_r;

  logic        s1_vld_r;
  cmd_t        s1_cmd_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        produces, out_free, s1_adv;
  dir_ctl_t    send_ctl, recv_ctl;
  logic [7:0]  send_res, recv_res;
  logic [7:0]  res_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= KEY_LOW_RESET;
      key_hi_r <= KEY_HIGH_RESET;
      dec_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY_LO: key_lo_r <= cfg_wdata;
        REG_KEY_HI: key_hi_r <= cfg_wdata;
        REG_DEC_EN: dec_en_r <= cfg_wdata[0];
        REG_NONE:   ;
        default:    ;
      endcase
    end
  end

  assign produces = (s1_cmd_r == CMD_ENC) || (s1_cmd_r == CMD_DEC);
  assign out_free = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && (!produces || out_free);
  assign in_ready = rst_n && (!s1_vld_r || s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_byte_r <= in_in_byte;
      s1_last_r <= in_last;
    end
  end

  always_comb begin
    send_ctl.step   = s1_adv && (s1_cmd_r == CMD_ENC);
    send_ctl.last   = s1_last_r;
    send_ctl.reload = s1_adv && (s1_cmd_r == CMD_NEWS);
    recv_ctl.step   = s1_adv && (s1_cmd_r == CMD_DEC) && dec_en_r;
    recv_ctl.last   = s1_last_r;
    recv_ctl.reload = send_ctl.reload;
  end

  cxpc_dir u_send (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (send_ctl),
    .init_key     ({key_hi_r, key_lo_r}),
    .chain_on_out (1'b1),
    .data_in      (s1_byte_r),
    .data_out     (send_res)
  );

  cxpc_dir u_recv (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (recv_ctl),
    .init_key     ({key_hi_r, key_lo_r}),
    .chain_on_out (1'b0),
    .data_in      (s1_byte_r),
    .data_out     (recv_res)
  );

  always_comb begin
    case (s1_cmd_r)
      CMD_ENC: res_byte = send_res;
      CMD_DEC: res_byte = dec_en_r ? recv_res : s1_byte_r;
      default: res_byte = s1_byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && produces) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && produces) begin
      out_byte_r <= res_byte;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_out_byte = out_byte_r;
  assign out_out_last = out_last_r;

endmodule

@@ design/cxpc_checker.sv @@
// ----------------------------------------------------------------------------
// Chained XOR packet cipher checker
// Port-level properties of the cipher, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_xor_packet_cipher_assert.svh"

module cxpc_checker
  import cxpc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_out_byte,
  input logic       out_out_last
);

  `CXPC_AST_NXT(a_out_hold, out_valid && !out_ready,
                out_valid && $stable(out_out_byte) && $stable(out_out_last))

  `CXPC_AST_IMP(a_stall_cause, !in_ready, out_valid && !out_ready)

  `CXPC_AST_IMP(a_result_source, $rose(out_valid),
                $past(in_valid && in_ready &&
                      (in_command == CMD_ENC || in_command == CMD_DEC), 2))

endmodule

bind chained_xor_packet_cipher cxpc_checker u_cxpc_checker (.*);

@@ dv/chained_xor_packet_cipher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained XOR packet cipher testbench
// Drives byte requests into the cipher under random idling on both sides.
// A scoreboard tracks both direction keys, chains and byte counts and
// checks every returned byte and last flag in order. The run covers
// directed corner cases, a long packet in each direction, and random
// packet traffic under several key and decrypt settings.
// ----------------------------------------------------------------------------
module chained_xor_packet_cipher_tb;
  import cxpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_LEN    = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_byte_t;

  class cipher_scoreboard;
    logic [31:0]  key_lo_reg;
    logic [31:0]  key_hi_reg;
    logic         dec_en_reg;
    logic [63:0]  send_key;
    logic [63:0]  recv_key;
    logic [7:0]   send_chain;
    logic [7:0]   recv_chain;
    logic [15:0]  send_count;
    logic [15:0]  recv_count;
    cipher_byte_t expected_bytes[$];
    int unsigned  errors;

    function void power_on();
      key_lo_reg = KEY_LOW_RESET;
      key_hi_reg = KEY_HIGH_RESET;
      dec_en_reg = 1'b0;
      errors     = 0;
      reload();
    endfunction

    function void reload();
      send_key   = {key_hi_reg, key_lo_reg};
      recv_key   = {key_hi_reg, key_lo_reg};
      send_chain = '0;
      recv_chain = '0;
      send_count = '0;
      recv_count = '0;
    endfunction

    function logic [7:0] key_byte(logic [63:0] key, logic [15:0] pos);
      logic [63:0] shifted;
      shifted = key >> {pos[2:0], 3'b000};
      return shifted[7:0];
    endfunction

    function logic [63:0] advance_low(logic [63:0] key, logic [15:0] len);
      logic [31:0] low;
      low = key[31:0] + {16'd0, len};
      return {key[63:32], low};
    endfunction

    function void note_write(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_KEY_LO: key_lo_reg = data;
        REG_KEY_HI: key_hi_reg = data;
        REG_DEC_EN: dec_en_reg = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(cmd_t cmd, logic [7:0] data, logic last);
      cipher_byte_t res;
      res.last = last;
      case (cmd)
        CMD_NEWS: begin
          reload();
          return;
        end
        CMD_NONE: return;
        CMD_ENC: begin
          res.data   = data ^ key_byte(send_key, send_count) ^ send_chain;
          send_chain = res.data;
          send_count = send_count + 16'd1;
          if (last) begin
            send_key   = advance_low(send_key, send_count);
            send_chain = '0;
            send_count = '0;
          end
        end
        default: begin
          if (!dec_en_reg) begin
            res.data = data;
          end else begin
            res.data   = data ^ key_byte(recv_key, recv_count) ^ recv_chain;
            recv_chain = data;
            recv_count = recv_count + 16'd1;
            if (last) begin
              recv_key   = advance_low(recv_key, recv_count);
              recv_chain = '0;
              recv_count = '0;
            end
          end
        end
      endcase
      expected_bytes.push_back(res);
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      cipher_byte_t want;
      if (expected_bytes.size() == 0) begin
        if (errors < 10)
          $display("unexpected byte: data %h last %b", data, last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data || last !== want.last) begin
        if (errors < 10)
          $display("byte mismatch: expected data %h last %b, got data %h last %b",
                   want.data, want.last, data, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_NONE;
  logic [7:0]  in_in_byte = '0;
  logic        in_last    = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_out_last;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_idx    = REG_KEY_LO;
  logic [31:0] cfg_wdata  = '0;

  cipher_scoreboard sb;
  bit               idle_en = 1'b0;
  int unsigned      sent    = 0;
  int unsigned      cycles  = 0;

  chained_xor_packet_cipher u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_in_byte   (in_in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_out_last (out_out_last),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("chained_xor_packet_cipher regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_byte(out_out_byte, out_out_last);
  end

  // stall the result side in bursts
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_req(cmd_t cmd, logic [7:0] data, logic last);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_in_byte <= data;
    in_last    <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, data, last);
    if (cmd != CMD_NONE) sent++;
  endtask

  task automatic hold_off(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_en && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 13));
  endtask

  // drop valid and let the pipeline empty, including requests with no result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.note_write(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_packet(cmd_t dir, int unsigned len, bit close);
    for (int unsigned i = 0; i < len; i++) begin
      maybe_idle();
      send_req(dir, 8'($urandom_range(0, 255)), close && (i == len - 1));
    end
  endtask

  task automatic send_pair(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      maybe_idle();
      send_req(CMD_ENC, 8'($urandom_range(0, 255)), i == len - 1);
      maybe_idle();
      send_req(CMD_DEC, 8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned pick;
    logic [31:0] key_lo;
    logic [31:0] key_hi;

    sb = new;
    sb.power_on();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keys, decrypt disabled
    send_req(CMD_ENC, 8'h00, 1'b0);
    send_req(CMD_ENC, 8'hFF, 1'b0);
    send_req(CMD_ENC, 8'h5A, 1'b1);
    send_req(CMD_ENC, 8'h3C, 1'b1);
    send_req(CMD_DEC, 8'hA5, 1'b0);
    send_req(CMD_DEC, 8'h00, 1'b1);
    send_req(CMD_NONE, 8'hFF, 1'b1);
    wait_idle();
    cfg_write(REG_DEC_EN, 32'd1);
    cfg_write(REG_KEY_LO, 32'hFFFF_FFFF);
    cfg_write(REG_KEY_HI, 32'h0000_0000);
    cfg_write(REG_NONE, 32'hFFFF_FFFF);
    // new key words stay unused until the next session
    send_req(CMD_DEC, 8'h81, 1'b1);
    send_req(CMD_NEWS, 8'h00, 1'b0);
    send_req(CMD_DEC, 8'hFF, 1'b0);
    send_req(CMD_DEC, 8'h00, 1'b1);
    send_req(CMD_ENC, 8'h80, 1'b1);
    send_req(CMD_ENC, 8'h11, 1'b0);
    send_req(CMD_NEWS, 8'h77, 1'b1);
    send_req(CMD_ENC, 8'h22, 1'b1);
    wait_idle();
    cfg_write(REG_KEY_HI, 32'hFFFF_FFFF);
    cfg_write(REG_KEY_LO, 32'h0000_0000);
    cfg_write(REG_DEC_EN, 32'd0);
    send_req(CMD_NEWS, 8'hFF, 1'b0);
    send_req(CMD_ENC, 8'hFF, 1'b1);
    send_req(CMD_DEC, 8'hFF, 1'b1);

    // one long packet per direction, interleaved
    wait_idle();
    cfg_write(REG_DEC_EN, 32'd1);
    send_req(CMD_NEWS, 8'h00, 1'b0);
    for (int unsigned i = 0; i < LONG_LEN; i++) begin
      send_req(CMD_ENC, 8'($urandom_range(0, 255)), i == LONG_LEN - 1);
      send_req(CMD_DEC, 8'($urandom_range(0, 255)), i == LONG_LEN - 1);
    end
    send_pair(3);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: begin
          key_lo = 32'h0000_0000;
          key_hi = 32'h0000_0000;
        end
        1: begin
          key_lo = 32'hFFFF_FFFF;
          key_hi = 32'hFFFF_FFFF;
        end
        2: begin
          key_lo = 32'hFFFF_FF00 | $urandom_range(0, 255);
          key_hi = $urandom;
        end
        default: begin
          key_lo = $urandom;
          key_hi = $urandom;
        end
      endcase
      cfg_write(REG_KEY_LO, key_lo);
      cfg_write(REG_KEY_HI, key_hi);
      cfg_write(REG_DEC_EN, (p != 1 && p != 4) ? 32'd1 : 32'd0);
      idle_en = (p != 5);
      if (p != 3)
        send_req(CMD_NEWS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      target = sent + 235;
      while (sent < target) begin
        if (p != 5 && $urandom_range(0, 15) == 0) idle_en = !idle_en;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_packet(cmd_t'($urandom_range(0, 1)),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12), 1'b1);
        end else if (pick < 78) begin
          send_pair($urandom_range(1, 10));
        end else if (pick < 86) begin
          // broken packet: no last byte
          send_packet(cmd_t'($urandom_range(0, 1)), $urandom_range(1, 8), 1'b0);
        end else if (pick < 91) begin
          maybe_idle();
          send_req(CMD_NEWS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (pick < 96) begin
          maybe_idle();
          send_req(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (p != 5) begin
          // hold requests until every result is back
          wait_idle();
        end
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0)
      $display("chained_xor_packet_cipher regression: pass");
    else
      $display("chained_xor_packet_cipher regression: fail");
    $finish;
  end

endmodule
